[src/wrsi_pkg.sv]
// Shared constants and types for the Wilder RSI tracker.
package wrsi_pkg;

   localparam int PRICE_WIDTH  = 32;
   localparam int FRAC_BITS    = 16;
   localparam int AVG_WIDTH    = 64;
   localparam int PERIOD_WIDTH = 8;
   localparam int LEVEL_WIDTH  = 14;
   localparam int COUNT_WIDTH  = PERIOD_WIDTH + 1;
   localparam int CSR_IDX_W    = 2;

   // Long division by the period: dividend is the average left-aligned over
   // AVG_WIDTH + FRAC_BITS bits.
   localparam int DIVD_WIDTH   = AVG_WIDTH + FRAC_BITS;
   localparam int RSI_BITS     = 14;
   localparam int PROD_WIDTH   = AVG_WIDTH + RSI_BITS;
   localparam int DEN_WIDTH    = AVG_WIDTH + 1;
   localparam int STEP_WIDTH   = 7;

   localparam logic [RSI_BITS-1:0]    RSI_SCALE   = 14'd10000;
   localparam logic [RSI_BITS-1:0]    RSI_NEUTRAL = 14'd5000;
   localparam logic [STEP_WIDTH-1:0]  STEPS_FIX   = 7'(DIVD_WIDTH - 1);
   localparam logic [STEP_WIDTH-1:0]  STEPS_SMOOTH = 7'(AVG_WIDTH - 1);
   localparam logic [STEP_WIDTH-1:0]  STEPS_MUL   = 7'(RSI_BITS - 1);
   localparam logic [STEP_WIDTH-1:0]  STEPS_RDIV  = 7'(PROD_WIDTH - 1);

   localparam logic [CSR_IDX_W-1:0] REG_PERIOD     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OVERBOUGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OVERSOLD   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIN,
      ST_MUL,
      ST_RDIV,
      ST_DONE
   } state_type;

endpackage

[src/wilder_rsi_tracker.sv]
// Wilder RSI tracker: bit-serial dividers and sequencer, one price per pass.
//
// Usage: one closing price enters on the req_ channel (req_valid/req_stall)
// and exactly one result leaves on the rsp_ channel (rsp_valid/rsp_stall).
// Registers are written over the csr_ channel (csr_valid/csr_ready, index
// 0 period, 1 overbought level, 2 oversold level); the user must write them
// only while the block is idle, which the block itself does not enforce.
// Sequencing: a price is taken only in the idle state, one at a time. The
// first price and warm-up prices need no division. The price that ends the
// warm-up runs an 80-step radix-2 division by the period in two lanes (gain
// and loss together). Each smoothing price runs a 64-step division of both
// averages by the period, a 14-step shift-add multiply by 10000 and a
// 78-step radix-2 division for the RSI ratio; these serial units set the
// rate. With a zero average loss the multiply and ratio division are skipped.
// Reset clears the price history, count and averages and loads the
// register defaults (period 14, levels 7000 and 3000).
// A finished result sits in the output register; the next price is taken
// while it waits. If the receiver still stalls when the following result is
// ready, the sequencer holds that result and takes no further price.
module wilder_rsi_tracker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [wrsi_pkg::PRICE_WIDTH-1:0]   req_price,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [wrsi_pkg::RSI_BITS-1:0]      rsp_rsi_hundredths,
   output logic                               rsp_rsi_valid,
   output logic                               rsp_overbought,
   output logic                               rsp_oversold,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wrsi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wrsi_pkg::LEVEL_WIDTH-1:0]   csr_data
);
   import wrsi_pkg::*;

   state_type state_ff, state_in;

   logic [PERIOD_WIDTH-1:0] period_ff;
   logic [LEVEL_WIDTH-1:0]  ob_level_ff, os_level_ff;
   logic [PRICE_WIDTH-1:0]  prev_price_ff;
   logic [COUNT_WIDTH-1:0]  count_ff;
   logic [AVG_WIDTH-1:0]    avg_gain_ff, avg_loss_ff;

   logic [DIVD_WIDTH-1:0]   divd_gain_ff, divd_loss_ff;
   logic [PERIOD_WIDTH-1:0] rem_gain_ff, rem_loss_ff;
   logic [AVG_WIDTH-1:0]    quo_gain_ff, quo_loss_ff;
   logic                    up_gain_ff, up_loss_ff, mode_fix_ff;
   logic [STEP_WIDTH-1:0]   step_ff;

   logic [PROD_WIDTH-1:0]   prod_ff;
   logic [DEN_WIDTH-1:0]    den_ff, rrem_ff;
   logic [RSI_BITS-1:0]     rquo_ff;

   logic [RSI_BITS-1:0]     res_rsi_ff;
   logic                    res_valid_ff;
   logic                    rsp_valid_ff;

   // Decisions at the transfer of a price
   logic                    accept;
   logic [PERIOD_WIDTH-1:0] p_eff;
   logic [PRICE_WIDTH-1:0]  gain, loss;
   logic                    is_first, is_warm, is_warm_end;
   logic [AVG_WIDTH-1:0]    sum_gain, sum_loss, move_gain, move_loss;
   logic [AVG_WIDTH-1:0]    num_gain, num_loss;
   logic                    mg_up, ml_up;
   logic [AVG_WIDTH-1:0]    fin_gain_in, fin_loss_in;
   logic                    out_free, step_last;

   always_comb begin
      accept      = req_valid && !req_stall;
      p_eff       = (period_ff == '0) ? PERIOD_WIDTH'(1) : period_ff;
      gain        = (req_price > prev_price_ff) ? req_price - prev_price_ff : '0;
      loss        = (req_price < prev_price_ff) ? prev_price_ff - req_price : '0;
      is_first    = (count_ff == '0);
      is_warm     = !is_first && (count_ff <= {1'b0, p_eff});
      is_warm_end = is_warm && (count_ff == {1'b0, p_eff});
      sum_gain    = avg_gain_ff + AVG_WIDTH'(gain);
      sum_loss    = avg_loss_ff + AVG_WIDTH'(loss);
      move_gain   = {(AVG_WIDTH - PRICE_WIDTH - FRAC_BITS)'(0), gain, FRAC_BITS'(0)};
      move_loss   = {(AVG_WIDTH - PRICE_WIDTH - FRAC_BITS)'(0), loss, FRAC_BITS'(0)};
      mg_up       = move_gain >= avg_gain_ff;
      ml_up       = move_loss >= avg_loss_ff;
      // Falling average divides rounded up, so bias by period minus one
      num_gain    = mg_up ? move_gain - avg_gain_ff
                          : avg_gain_ff - move_gain + AVG_WIDTH'(p_eff - 1'b1);
      num_loss    = ml_up ? move_loss - avg_loss_ff
                          : avg_loss_ff - move_loss + AVG_WIDTH'(p_eff - 1'b1);
      // Finish the averages from the quotients
      if (mode_fix_ff) begin
         fin_gain_in = quo_gain_ff;
         fin_loss_in = quo_loss_ff;
      end else begin
         fin_gain_in = up_gain_ff ? avg_gain_ff + quo_gain_ff : avg_gain_ff - quo_gain_ff;
         fin_loss_in = up_loss_ff ? avg_loss_ff + quo_loss_ff : avg_loss_ff - quo_loss_ff;
      end
      out_free  = !rsp_valid_ff || !rsp_stall;
      step_last = (step_ff == '0);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_first || (is_warm && !is_warm_end)) state_in = ST_DONE;
               else state_in = ST_DIV;
            end
         end
         ST_DIV:  if (step_last) state_in = ST_FIN;
         ST_FIN: begin
            if (mode_fix_ff || fin_loss_in == '0) state_in = ST_DONE;
            else state_in = ST_MUL;
         end
         ST_MUL:  if (step_last) state_in = ST_RDIV;
         ST_RDIV: if (step_last) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      csr_ready = 1'b1;
      rsp_valid = rsp_valid_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         period_ff     <= 8'd14;
         ob_level_ff   <= 14'd7000;
         os_level_ff   <= 14'd3000;
         prev_price_ff <= '0;
         count_ff      <= '0;
         avg_gain_ff   <= '0;
         avg_loss_ff   <= '0;
      end else begin
         state_ff <= state_in;
         // Register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PERIOD:     period_ff   <= csr_data[PERIOD_WIDTH-1:0];
               REG_OVERBOUGHT: ob_level_ff <= csr_data;
               REG_OVERSOLD:   os_level_ff <= csr_data;
               default: ;
            endcase
         end
         // Drop a result once transferred, load the next when finished
         if (state_ff == ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         // History update at the transfer of a price
         if (accept) begin
            prev_price_ff <= req_price;
            if (is_first) begin
               count_ff <= COUNT_WIDTH'(1);
            end else if (is_warm) begin
               count_ff <= count_ff + 1'b1;
               if (!is_warm_end) begin
                  avg_gain_ff <= sum_gain;
                  avg_loss_ff <= sum_loss;
               end
            end else begin
               count_ff <= {1'b0, p_eff} + 1'b1;
            end
         end
         if (state_ff == ST_FIN) begin
            avg_gain_ff <= fin_gain_in;
            avg_loss_ff <= fin_loss_in;
         end
      end
   end

   // Serial datapath: period divider lanes, multiply and ratio divider
   logic [PERIOD_WIDTH:0]  tr_gain, tr_loss;
   logic                   ge_gain, ge_loss;
   logic [DEN_WIDTH:0]     tr_rsi;
   logic                   ge_rsi;
   logic [3:0]             mul_idx;

   always_comb begin
      tr_gain = {rem_gain_ff, divd_gain_ff[DIVD_WIDTH-1]};
      tr_loss = {rem_loss_ff, divd_loss_ff[DIVD_WIDTH-1]};
      ge_gain = tr_gain >= {1'b0, p_eff};
      ge_loss = tr_loss >= {1'b0, p_eff};
      tr_rsi  = {rrem_ff, prod_ff[PROD_WIDTH-1]};
      ge_rsi  = tr_rsi >= {1'b0, den_ff};
      mul_idx = step_ff[3:0];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rem_gain_ff <= '0;
               rem_loss_ff <= '0;
               quo_gain_ff <= '0;
               quo_loss_ff <= '0;
               up_gain_ff  <= mg_up;
               up_loss_ff  <= ml_up;
               res_rsi_ff  <= RSI_NEUTRAL;
               res_valid_ff <= 1'b0;
               if (is_warm_end) begin
                  divd_gain_ff <= {sum_gain, FRAC_BITS'(0)};
                  divd_loss_ff <= {sum_loss, FRAC_BITS'(0)};
                  mode_fix_ff  <= 1'b1;
                  step_ff      <= STEPS_FIX;
               end else begin
                  divd_gain_ff <= {num_gain, FRAC_BITS'(0)};
                  divd_loss_ff <= {num_loss, FRAC_BITS'(0)};
                  mode_fix_ff  <= 1'b0;
                  step_ff      <= STEPS_SMOOTH;
               end
            end
         end
         ST_DIV: begin
            // One quotient bit per lane per cycle
            divd_gain_ff <= divd_gain_ff << 1;
            divd_loss_ff <= divd_loss_ff << 1;
            rem_gain_ff  <= ge_gain ? PERIOD_WIDTH'(tr_gain - {1'b0, p_eff})
                                    : tr_gain[PERIOD_WIDTH-1:0];
            rem_loss_ff  <= ge_loss ? PERIOD_WIDTH'(tr_loss - {1'b0, p_eff})
                                    : tr_loss[PERIOD_WIDTH-1:0];
            quo_gain_ff  <= {quo_gain_ff[AVG_WIDTH-2:0], ge_gain};
            quo_loss_ff  <= {quo_loss_ff[AVG_WIDTH-2:0], ge_loss};
            step_ff      <= step_ff - 1'b1;
         end
         ST_FIN: begin
            if (!mode_fix_ff) begin
               res_valid_ff <= 1'b1;
               res_rsi_ff   <= RSI_SCALE;
            end
            den_ff  <= {1'b0, fin_gain_in} + {1'b0, fin_loss_in};
            prod_ff <= '0;
            step_ff <= STEPS_MUL;
         end
         ST_MUL: begin
            // Shift-add by the scale constant, top bit first
            prod_ff <= (prod_ff << 1)
                       + (RSI_SCALE[mul_idx] ? PROD_WIDTH'(avg_gain_ff) : '0);
            rrem_ff <= '0;
            rquo_ff <= '0;
            step_ff <= step_last ? STEPS_RDIV : step_ff - 1'b1;
         end
         ST_RDIV: begin
            prod_ff <= prod_ff << 1;
            rrem_ff <= ge_rsi ? DEN_WIDTH'(tr_rsi - {1'b0, den_ff})
                              : tr_rsi[DEN_WIDTH-1:0];
            rquo_ff <= {rquo_ff[RSI_BITS-2:0], ge_rsi};
            step_ff <= step_ff - 1'b1;
            if (step_last) res_rsi_ff <= {rquo_ff[RSI_BITS-2:0], ge_rsi};
         end
         default: ;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_rsi_hundredths <= res_rsi_ff;
         rsp_rsi_valid      <= res_valid_ff;
         rsp_overbought     <= res_valid_ff && (res_rsi_ff > ob_level_ff);
         rsp_oversold       <= res_valid_ff && (res_rsi_ff < os_level_ff);
      end
   end

   // Count never passes the largest period plus one
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(256))
      else $error("sample count out of range");

   // A result on the port is never above full scale
   a_rsi_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rsi_hundredths <= RSI_SCALE)
      else $error("rsi above full scale");

   // A warm-up result is neutral and carries no flags
   a_warm_neutral: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_rsi_valid) |->
         (rsp_rsi_hundredths == RSI_NEUTRAL && !rsp_overbought && !rsp_oversold))
      else $error("warm-up result not neutral");

   // Leaving the ratio division always yields a valid result
   a_rdiv_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDIV && step_last) |=> (state_ff == ST_DONE && res_valid_ff))
      else $error("ratio division did not finish a valid result");

endmodule
